// ----- rtl/core/tbs_pkg.sv -----
package tbs_pkg;

  localparam int TIME_WIDTH     = 24;
  localparam int ID_WIDTH       = 16;
  localparam int RAND_WIDTH     = 16;
  localparam int SEQ_WIDTH      = 16;
  localparam int ETX_WIDTH      = 16;
  localparam int ARG_WIDTH      = (ETX_WIDTH > ID_WIDTH) ? ETX_WIDTH : ID_WIDTH;
  localparam int OP_WIDTH       = 3;
  localparam int CFG_ADDR_WIDTH = 4;
  localparam int CFG_DATA_WIDTH = 32;
  localparam int QUEUE_DEPTH    = 2;
  localparam int PROD_WIDTH     = TIME_WIDTH + RAND_WIDTH;

  localparam logic [TIME_WIDTH-1:0] MIN_TICKS_RESET = TIME_WIDTH'(64);
  localparam logic [TIME_WIDTH-1:0] MAX_TICKS_RESET = TIME_WIDTH'(65536);

  localparam logic [OP_WIDTH-1:0] OP_TICK       = 3'd0;
  localparam logic [OP_WIDTH-1:0] OP_SET_ETX    = 3'd1;
  localparam logic [OP_WIDTH-1:0] OP_NEW_PARENT = 3'd2;
  localparam logic [OP_WIDTH-1:0] OP_RESET      = 3'd3;
  localparam logic [OP_WIDTH-1:0] OP_RESET_PULL = 3'd4;
  localparam logic [OP_WIDTH-1:0] OP_NO_ENERGY  = 3'd5;

  localparam logic [1:0] REG_MIN_TICKS = 2'd0;
  localparam logic [1:0] REG_MAX_TICKS = 2'd1;
  localparam logic [1:0] REG_STATIC    = 2'd2;
  localparam logic [1:0] REG_NODE_ID   = 2'd3;

  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_SET_ETX,
    CMD_NEW_PARENT,
    CMD_RESET,
    CMD_RESET_PULL,
    CMD_NO_ENERGY
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e             kind;
    logic [ARG_WIDTH-1:0]  arg;
    logic [RAND_WIDTH-1:0] frac;
  } cmd_t;

  typedef struct packed {
    logic [TIME_WIDTH-1:0] min_ticks;
    logic [TIME_WIDTH-1:0] max_ticks;
    logic                  static_mode;
    logic [ID_WIDTH-1:0]   node_id;
  } cfg_t;

endpackage

// ----- rtl/core/tbs_regs.sv -----
module tbs_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tbs_pkg::CFG_ADDR_WIDTH-1:0]  paddr,
  input  logic [tbs_pkg::CFG_DATA_WIDTH-1:0]  pwdata,
  output logic [tbs_pkg::CFG_DATA_WIDTH-1:0]  prdata,
  output logic                                pready,
  output tbs_pkg::cfg_t                       cfg_o
);

  tbs_pkg::cfg_t cfg_q;
  logic          wr_en;
  logic [1:0]    reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_ticks   <= tbs_pkg::MIN_TICKS_RESET;
      cfg_q.max_ticks   <= tbs_pkg::MAX_TICKS_RESET;
      cfg_q.static_mode <= 1'b0;
      cfg_q.node_id     <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        tbs_pkg::REG_MIN_TICKS: cfg_q.min_ticks   <= pwdata[tbs_pkg::TIME_WIDTH-1:0];
        tbs_pkg::REG_MAX_TICKS: cfg_q.max_ticks   <= pwdata[tbs_pkg::TIME_WIDTH-1:0];
        tbs_pkg::REG_STATIC:    cfg_q.static_mode <= pwdata[0];
        tbs_pkg::REG_NODE_ID:   cfg_q.node_id     <= pwdata[tbs_pkg::ID_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tbs_pkg::REG_MIN_TICKS: prdata = tbs_pkg::CFG_DATA_WIDTH'(cfg_q.min_ticks);
      tbs_pkg::REG_MAX_TICKS: prdata = tbs_pkg::CFG_DATA_WIDTH'(cfg_q.max_ticks);
      tbs_pkg::REG_STATIC:    prdata = tbs_pkg::CFG_DATA_WIDTH'(cfg_q.static_mode);
      tbs_pkg::REG_NODE_ID:   prdata = tbs_pkg::CFG_DATA_WIDTH'(cfg_q.node_id);
      default:                prdata = '0;
    endcase
  end

endmodule

// ----- rtl/core/tbs_front.sv -----
module tbs_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [tbs_pkg::OP_WIDTH-1:0]    opcode_i,
  input  logic [tbs_pkg::ETX_WIDTH-1:0]   etx_value_i,
  input  logic [tbs_pkg::ID_WIDTH-1:0]    parent_id_i,
  input  logic [tbs_pkg::RAND_WIDTH-1:0]  random_fraction_i,
  output logic                            cmd_valid_o,
  output tbs_pkg::cmd_t                   cmd_o,
  input  logic                            cmd_pop_i
);

  localparam int PTR_WIDTH = (tbs_pkg::QUEUE_DEPTH > 1) ? $clog2(tbs_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_WIDTH = $clog2(tbs_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_WIDTH-1:0] LAST_PTR = PTR_WIDTH'(tbs_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_WIDTH-1:0] FULL_CNT = CNT_WIDTH'(tbs_pkg::QUEUE_DEPTH);

  tbs_pkg::cmd_t          queue_q [tbs_pkg::QUEUE_DEPTH];
  logic [PTR_WIDTH-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_WIDTH-1:0]   count_q;
  tbs_pkg::cmd_t          dec_cmd;
  logic                   dec_ok;
  logic                   push;

  // classify: unused opcodes are taken and dropped
  always_comb begin
    dec_cmd.arg  = tbs_pkg::ARG_WIDTH'(etx_value_i);
    dec_cmd.frac = random_fraction_i;
    dec_cmd.kind = tbs_pkg::CMD_TICK;
    dec_ok       = 1'b1;
    case (opcode_i)
      tbs_pkg::OP_TICK:       dec_cmd.kind = tbs_pkg::CMD_TICK;
      tbs_pkg::OP_SET_ETX:    dec_cmd.kind = tbs_pkg::CMD_SET_ETX;
      tbs_pkg::OP_NEW_PARENT: begin
        dec_cmd.kind = tbs_pkg::CMD_NEW_PARENT;
        dec_cmd.arg  = tbs_pkg::ARG_WIDTH'(parent_id_i);
      end
      tbs_pkg::OP_RESET:      dec_cmd.kind = tbs_pkg::CMD_RESET;
      tbs_pkg::OP_RESET_PULL: dec_cmd.kind = tbs_pkg::CMD_RESET_PULL;
      tbs_pkg::OP_NO_ENERGY:  dec_cmd.kind = tbs_pkg::CMD_NO_ENERGY;
      default:                dec_ok       = 1'b0;
    endcase
  end

  assign in_ready_o  = (count_q != FULL_CNT);
  assign push        = in_valid_i && in_ready_o && dec_ok;
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= dec_cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_WIDTH'(1);
      end
      if (cmd_pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_WIDTH'(1);
      end
      case ({push, cmd_pop_i})
        2'b10:   count_q <= count_q + CNT_WIDTH'(1);
        2'b01:   count_q <= count_q - CNT_WIDTH'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ----- rtl/core/tbs_back.sv -----
module tbs_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tbs_pkg::cfg_t                    cfg_i,
  input  logic                             cmd_valid_i,
  input  tbs_pkg::cmd_t                    cmd_i,
  output logic                             cmd_pop_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [tbs_pkg::SEQ_WIDTH-1:0]    sequence_res_o,
  output logic                             etx_known_o,
  output logic [tbs_pkg::ETX_WIDTH-1:0]    etx_to_root_o,
  output logic                             has_parent_o,
  output logic [tbs_pkg::ID_WIDTH-1:0]     parent_node_o,
  output logic                             pull_o,
  output logic [tbs_pkg::ID_WIDTH-1:0]     source_node_o,
  output logic [tbs_pkg::TIME_WIDTH-1:0]   next_interval_o
);

  localparam int TW = tbs_pkg::TIME_WIDTH;
  localparam int RW = tbs_pkg::RAND_WIDTH;
  localparam int PW = tbs_pkg::PROD_WIDTH;

  logic [tbs_pkg::SEQ_WIDTH-1:0] seq_q;
  logic [tbs_pkg::ETX_WIDTH-1:0] etx_q;
  logic                          etx_valid_q;
  logic [tbs_pkg::ID_WIDTH-1:0]  parent_q;
  logic                          parent_valid_q;
  logic                          pull_q;
  logic [TW-1:0]                 coeff_q;
  logic [TW-1:0]                 countdown_q;
  logic                          armed_q;
  logic                          out_valid_q;

  logic          is_tick, is_reset, fire, emit, slot_free, exec;
  logic [TW-1:0] cnt_dec, coeff_use, lower, span, interval_raw, interval, doubled, coeff_next;
  logic [PW-1:0] prod;
  logic          emit_pull, emit_parent_valid;
  logic [tbs_pkg::ID_WIDTH-1:0] emit_parent;

  assign is_tick  = (cmd_i.kind == tbs_pkg::CMD_TICK);
  assign is_reset = (cmd_i.kind == tbs_pkg::CMD_NEW_PARENT) ||
                    (cmd_i.kind == tbs_pkg::CMD_RESET) ||
                    (cmd_i.kind == tbs_pkg::CMD_RESET_PULL);
  assign cnt_dec  = countdown_q - TW'(1);
  assign fire     = is_tick && armed_q && (cnt_dec == '0);
  assign emit     = fire || is_reset;

  assign slot_free = !out_valid_q || out_ready_i;
  assign exec      = cmd_valid_i && (!emit || slot_free);
  assign cmd_pop_o = exec;

  // interval = coeff/2 + (coeff - coeff/2) * frac / 2^RW
  assign coeff_use    = is_reset ? cfg_i.min_ticks : coeff_q;
  assign lower        = coeff_use >> 1;
  assign span         = coeff_use - lower;
  assign prod         = PW'(span) * PW'(cmd_i.frac);
  assign interval_raw = lower + prod[PW-1:RW];
  assign interval     = (interval_raw == '0) ? TW'(1) : interval_raw;
  assign doubled      = coeff_use[TW-1] ? '1 : {coeff_use[TW-2:0], 1'b0};
  assign coeff_next   = cfg_i.static_mode ? coeff_use :
                        ((doubled < cfg_i.max_ticks) ? doubled : cfg_i.max_ticks);

  assign emit_pull         = pull_q || (cmd_i.kind == tbs_pkg::CMD_RESET_PULL);
  assign emit_parent_valid = parent_valid_q || (cmd_i.kind == tbs_pkg::CMD_NEW_PARENT);
  assign emit_parent       = (cmd_i.kind == tbs_pkg::CMD_NEW_PARENT) ?
                             cmd_i.arg[tbs_pkg::ID_WIDTH-1:0] : parent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q          <= '0;
      etx_q          <= '0;
      etx_valid_q    <= 1'b0;
      parent_q       <= '0;
      parent_valid_q <= 1'b0;
      pull_q         <= 1'b0;
      coeff_q        <= tbs_pkg::MIN_TICKS_RESET;
      countdown_q    <= '0;
      armed_q        <= 1'b0;
    end else if (exec) begin
      if (emit) begin
        seq_q          <= seq_q + tbs_pkg::SEQ_WIDTH'(1);
        pull_q         <= 1'b0;
        countdown_q    <= interval;
        armed_q        <= 1'b1;
        coeff_q        <= coeff_next;
        parent_q       <= emit_parent;
        parent_valid_q <= emit_parent_valid;
      end else begin
        case (cmd_i.kind)
          tbs_pkg::CMD_TICK: begin
            if (armed_q) begin
              countdown_q <= cnt_dec;
            end
          end
          tbs_pkg::CMD_SET_ETX: begin
            etx_q       <= cmd_i.arg[tbs_pkg::ETX_WIDTH-1:0];
            etx_valid_q <= 1'b1;
          end
          tbs_pkg::CMD_NO_ENERGY: begin
            etx_q          <= '0;
            etx_valid_q    <= 1'b0;
            parent_q       <= '0;
            parent_valid_q <= 1'b0;
            pull_q         <= 1'b0;
            coeff_q        <= cfg_i.min_ticks;
            countdown_q    <= '0;
            armed_q        <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec && emit) begin
      sequence_res_o  <= seq_q;
      etx_known_o     <= etx_valid_q;
      etx_to_root_o   <= etx_q;
      has_parent_o    <= emit_parent_valid;
      parent_node_o   <= emit_parent;
      pull_o          <= emit_pull;
      source_node_o   <= cfg_i.node_id;
      next_interval_o <= interval;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/core/trickle_beacon_scheduler.sv -----
// Trickle beacon scheduler.
// Input channel (in_valid_i/in_ready_o) takes one event item per cycle: tick,
// set ETX, new parent, trickle reset, reset with pull, out of energy. Items go
// into a two-entry command queue; the executor pops one command per cycle.
// Output channel (out_valid_o/out_ready_i) carries one beacon item for every
// reset-class event and for every tick that runs the armed countdown to zero.
// An accepted item is first written into the queue; the executor then takes it
// from the queue head and loads its beacon into the output register.
// Throughput: one item per cycle; the executor computes the next interval with
// a single 24x16 multiply and updates all state in the same cycle.
// When the receiver stalls, the held beacon stays in the output register, the
// executor keeps running non-beacon commands and blocks only on the next
// beacon; the queue then fills and in_ready_o drops.
// Reset (rst_ni low, async): queue empty, no beacon pending, sequence 0, no
// ETX, no parent, timer disarmed, coefficient 64; registers take their defaults.
// Config registers (APB, byte address 4*i): write only while idle (unchecked).
module trickle_beacon_scheduler (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tbs_pkg::CFG_ADDR_WIDTH-1:0]  paddr,
  input  logic [tbs_pkg::CFG_DATA_WIDTH-1:0]  pwdata,
  output logic [tbs_pkg::CFG_DATA_WIDTH-1:0]  prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [tbs_pkg::OP_WIDTH-1:0]        opcode_i,
  input  logic [tbs_pkg::ETX_WIDTH-1:0]       etx_value_i,
  input  logic [tbs_pkg::ID_WIDTH-1:0]        parent_id_i,
  input  logic [tbs_pkg::RAND_WIDTH-1:0]      random_fraction_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [tbs_pkg::SEQ_WIDTH-1:0]       sequence_res_o,
  output logic                                etx_known_o,
  output logic [tbs_pkg::ETX_WIDTH-1:0]       etx_to_root_o,
  output logic                                has_parent_o,
  output logic [tbs_pkg::ID_WIDTH-1:0]        parent_node_o,
  output logic                                pull_o,
  output logic [tbs_pkg::ID_WIDTH-1:0]        source_node_o,
  output logic [tbs_pkg::TIME_WIDTH-1:0]      next_interval_o
);

  tbs_pkg::cfg_t cfg;
  tbs_pkg::cmd_t cmd;
  logic          cmd_valid;
  logic          cmd_pop;

  tbs_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tbs_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .opcode_i          (opcode_i),
    .etx_value_i       (etx_value_i),
    .parent_id_i       (parent_id_i),
    .random_fraction_i (random_fraction_i),
    .cmd_valid_o       (cmd_valid),
    .cmd_o             (cmd),
    .cmd_pop_i         (cmd_pop)
  );

  tbs_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_valid_i     (cmd_valid),
    .cmd_i           (cmd),
    .cmd_pop_o       (cmd_pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .sequence_res_o  (sequence_res_o),
    .etx_known_o     (etx_known_o),
    .etx_to_root_o   (etx_to_root_o),
    .has_parent_o    (has_parent_o),
    .parent_node_o   (parent_node_o),
    .pull_o          (pull_o),
    .source_node_o   (source_node_o),
    .next_interval_o (next_interval_o)
  );

  a_pop_needs_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("command popped from empty queue");

  a_reset_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_pop && (cmd.kind == tbs_pkg::CMD_RESET || cmd.kind == tbs_pkg::CMD_RESET_PULL ||
                 cmd.kind == tbs_pkg::CMD_NEW_PARENT)) |=> out_valid_o)
    else $error("trickle reset did not produce a beacon");

  a_no_energy_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_pop && cmd.kind == tbs_pkg::CMD_NO_ENERGY && out_ready_i) |=> !out_valid_o)
    else $error("out-of-energy event produced a beacon");

  a_set_etx_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_pop && cmd.kind == tbs_pkg::CMD_SET_ETX && out_ready_i) |=> !out_valid_o)
    else $error("set ETX event produced a beacon");

endmodule

// ----- dv/trickle_beacon_scheduler_checker.sv -----
module trickle_beacon_scheduler_checker
  import tbs_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [CFG_ADDR_WIDTH-1:0] paddr,
  input  logic [CFG_DATA_WIDTH-1:0] pwdata,
  input  logic                      pready,
  input  logic                      in_valid_i,
  input  logic                      in_ready_o,
  input  logic [OP_WIDTH-1:0]       opcode_i,
  input  logic [ETX_WIDTH-1:0]      etx_value_i,
  input  logic [ID_WIDTH-1:0]       parent_id_i,
  input  logic [RAND_WIDTH-1:0]     random_fraction_i,
  input  logic                      out_valid_o,
  input  logic                      out_ready_i,
  input  logic [SEQ_WIDTH-1:0]      sequence_res_o,
  input  logic                      etx_known_o,
  input  logic [ETX_WIDTH-1:0]      etx_to_root_o,
  input  logic                      has_parent_o,
  input  logic [ID_WIDTH-1:0]       parent_node_o,
  input  logic                      pull_o,
  input  logic [ID_WIDTH-1:0]       source_node_o,
  input  logic [TIME_WIDTH-1:0]     next_interval_o,
  output int                        mismatch_cnt_o,
  output int                        beacons_due_o,
  output int                        beacon_cnt_o
);

  typedef struct packed {
    logic [SEQ_WIDTH-1:0]  seq;
    logic                  etx_known;
    logic [ETX_WIDTH-1:0]  etx;
    logic                  has_parent;
    logic [ID_WIDTH-1:0]   parent;
    logic                  pull;
    logic [ID_WIDTH-1:0]   source;
    logic [TIME_WIDTH-1:0] interval;
  } beacon_t;

  logic [TIME_WIDTH-1:0] cfg_min;
  logic [TIME_WIDTH-1:0] cfg_max;
  logic                  cfg_static_mode;
  logic [ID_WIDTH-1:0]   cfg_node_id;

  logic [SEQ_WIDTH-1:0]  seq_q;
  logic [ETX_WIDTH-1:0]  etx_q;
  logic                  etx_ok_q;
  logic [ID_WIDTH-1:0]   parent_q;
  logic                  parent_ok_q;
  logic                  pull_q;
  logic [TIME_WIDTH-1:0] coeff_q;
  logic [TIME_WIDTH-1:0] countdown_q;
  logic                  armed_q;

  beacon_t beacons_due[$];

  function automatic logic [TIME_WIDTH-1:0] spread_interval(
    input logic [TIME_WIDTH-1:0] coeff,
    input logic [RAND_WIDTH-1:0] frac
  );
    logic [TIME_WIDTH-1:0] lower;
    logic [TIME_WIDTH-1:0] span;
    logic [PROD_WIDTH-1:0] prod;
    logic [TIME_WIDTH-1:0] ivl;
    lower = coeff >> 1;
    span  = coeff - lower;
    prod  = PROD_WIDTH'(span) * PROD_WIDTH'(frac);
    ivl   = lower + prod[PROD_WIDTH-1:RAND_WIDTH];
    if (ivl == '0) begin
      ivl = TIME_WIDTH'(1);
    end
    return ivl;
  endfunction

  function automatic logic [TIME_WIDTH-1:0] grown_coeff(input logic [TIME_WIDTH-1:0] coeff);
    logic [TIME_WIDTH:0] dbl;
    dbl = {coeff, 1'b0};
    if (dbl[TIME_WIDTH]) begin
      dbl = {1'b0, {TIME_WIDTH{1'b1}}};
    end
    return (dbl[TIME_WIDTH-1:0] < cfg_max) ? dbl[TIME_WIDTH-1:0] : cfg_max;
  endfunction

  function automatic string show(input beacon_t b);
    return $sformatf("seq=%h etx=%b/%h parent=%b/%h pull=%b src=%h ivl=%h",
                     b.seq, b.etx_known, b.etx, b.has_parent, b.parent, b.pull,
                     b.source, b.interval);
  endfunction

  task automatic flag_fault(input string what);
    mismatch_cnt_o++;
    if (mismatch_cnt_o <= 10) begin
      $display("%s", what);
    end
  endtask

  task automatic fire_beacon(input logic [RAND_WIDTH-1:0] frac);
    beacon_t b;
    b.seq        = seq_q;
    b.etx_known  = etx_ok_q;
    b.etx        = etx_q;
    b.has_parent = parent_ok_q;
    b.parent     = parent_q;
    b.pull       = pull_q;
    b.source     = cfg_node_id;
    b.interval   = spread_interval(coeff_q, frac);
    beacons_due.push_back(b);
    seq_q       = seq_q + 1'b1;
    pull_q      = 1'b0;
    countdown_q = b.interval;
    armed_q     = 1'b1;
    if (!cfg_static_mode) begin
      coeff_q = grown_coeff(coeff_q);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    beacon_t got;
    beacon_t want;
    if (!rst_ni) begin
      cfg_min         = MIN_TICKS_RESET;
      cfg_max         = MAX_TICKS_RESET;
      cfg_static_mode = 1'b0;
      cfg_node_id     = '0;
      seq_q           = '0;
      etx_q           = '0;
      etx_ok_q        = 1'b0;
      parent_q        = '0;
      parent_ok_q     = 1'b0;
      pull_q          = 1'b0;
      coeff_q         = MIN_TICKS_RESET;
      countdown_q     = '0;
      armed_q         = 1'b0;
      beacons_due.delete();
      mismatch_cnt_o  = 0;
      beacons_due_o   = 0;
      beacon_cnt_o    = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[CFG_ADDR_WIDTH-1:2])
          REG_MIN_TICKS: cfg_min = pwdata[TIME_WIDTH-1:0];
          REG_MAX_TICKS: cfg_max = pwdata[TIME_WIDTH-1:0];
          REG_STATIC:    cfg_static_mode = pwdata[0];
          REG_NODE_ID:   cfg_node_id = pwdata[ID_WIDTH-1:0];
          default: ;
        endcase
      end

      if (out_valid_o && out_ready_i) begin
        beacon_cnt_o++;
        got = {sequence_res_o, etx_known_o, etx_to_root_o, has_parent_o, parent_node_o,
               pull_o, source_node_o, next_interval_o};
        if (beacons_due.size() == 0) begin
          flag_fault({"unexpected beacon: ", show(got)});
        end else begin
          want = beacons_due.pop_front();
          if (got !== want) begin
            flag_fault({"beacon mismatch: expected ", show(want), " got ", show(got)});
          end
        end
      end

      if (in_valid_i && in_ready_o) begin
        case (opcode_i)
          OP_TICK: begin
            if (armed_q) begin
              countdown_q = countdown_q - 1'b1;
              if (countdown_q == '0) begin
                armed_q = 1'b0;
                fire_beacon(random_fraction_i);
              end
            end
          end
          OP_SET_ETX: begin
            etx_q    = etx_value_i;
            etx_ok_q = 1'b1;
          end
          OP_NEW_PARENT: begin
            parent_q    = parent_id_i;
            parent_ok_q = 1'b1;
            coeff_q     = cfg_min;
            fire_beacon(random_fraction_i);
          end
          OP_RESET: begin
            coeff_q = cfg_min;
            fire_beacon(random_fraction_i);
          end
          OP_RESET_PULL: begin
            pull_q  = 1'b1;
            coeff_q = cfg_min;
            fire_beacon(random_fraction_i);
          end
          OP_NO_ENERGY: begin
            etx_q       = '0;
            etx_ok_q    = 1'b0;
            parent_q    = '0;
            parent_ok_q = 1'b0;
            pull_q      = 1'b0;
            coeff_q     = cfg_min;
            countdown_q = '0;
            armed_q     = 1'b0;
          end
          default: ;
        endcase
      end
      beacons_due_o = beacons_due.size();
    end
  end

endmodule

// ----- dv/trickle_beacon_scheduler_tb.sv -----
module trickle_beacon_scheduler_tb;
  import tbs_pkg::*;

  localparam int LIMIT       = 200000;  // generous timeout for the whole run
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 155;
  localparam int HOLD_PHASE  = 9;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 4;

  localparam logic [OP_WIDTH-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_WIDTH-1:0] OP_SPARE_HI = 3'd7;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [CFG_ADDR_WIDTH-1:0] paddr;
  logic [CFG_DATA_WIDTH-1:0] pwdata;
  logic [CFG_DATA_WIDTH-1:0] prdata;
  logic                      pready;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [OP_WIDTH-1:0]       opcode_i;
  logic [ETX_WIDTH-1:0]      etx_value_i;
  logic [ID_WIDTH-1:0]       parent_id_i;
  logic [RAND_WIDTH-1:0]     random_fraction_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic [SEQ_WIDTH-1:0]      sequence_res_o;
  logic                      etx_known_o;
  logic [ETX_WIDTH-1:0]      etx_to_root_o;
  logic                      has_parent_o;
  logic [ID_WIDTH-1:0]       parent_node_o;
  logic                      pull_o;
  logic [ID_WIDTH-1:0]       source_node_o;
  logic [TIME_WIDTH-1:0]     next_interval_o;

  int   mismatch_cnt_o;
  int   beacons_due_o;
  int   beacon_cnt_o;
  int   cycle_cnt = 0;
  int   items_sent;
  int   send_idle_pct;
  int   recv_idle_pct;
  logic hold_rx;

  trickle_beacon_scheduler uut (.*);

  trickle_beacon_scheduler_checker beacon_watch (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("trickle_beacon_scheduler regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= !hold_rx && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [CFG_DATA_WIDTH-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  task automatic apply_setting(input int p);
    logic [TIME_WIDTH-1:0] min_t;
    logic [TIME_WIDTH-1:0] max_t;
    logic                  stat;
    logic [ID_WIDTH-1:0]   node;
    node = ID_WIDTH'($urandom);
    case (p)
      1:       begin min_t = 24'd0;       max_t = 24'd16;      stat = 1'b0; node = '1; end
      2:       begin min_t = 24'd1;       max_t = 24'd1;       stat = 1'b1; node = '0; end
      3:       begin min_t = 24'h800000;  max_t = 24'hFFFFFF;  stat = 1'b0; end
      4:       begin min_t = 24'hFFFFFF;  max_t = 24'hFFFFFF;  stat = 1'b0; end
      5:       begin min_t = 24'd40;      max_t = 24'd5;       stat = 1'b0; end
      6:       begin min_t = 24'd3;       max_t = 24'd12;      stat = 1'b1; end
      PHASES - 1: begin min_t = 24'd2;    max_t = 24'd64;      stat = 1'b0; end
      default: begin
        min_t = TIME_WIDTH'($urandom_range(24, 2));
        max_t = TIME_WIDTH'($urandom_range(300, 2));
        stat  = 1'($urandom_range(1));
      end
    endcase
    cfg_write(REG_MIN_TICKS, CFG_DATA_WIDTH'(min_t));
    cfg_write(REG_MAX_TICKS, CFG_DATA_WIDTH'(max_t));
    cfg_write(REG_STATIC, CFG_DATA_WIDTH'(stat));
    cfg_write(REG_NODE_ID, CFG_DATA_WIDTH'(node));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_item(
    input logic [OP_WIDTH-1:0]   op,
    input logic [ETX_WIDTH-1:0]  etx,
    input logic [ID_WIDTH-1:0]   par,
    input logic [RAND_WIDTH-1:0] frac
  );
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i        <= 1'b1;
    opcode_i          <= op;
    etx_value_i       <= etx;
    parent_id_i       <= par;
    random_fraction_i <= frac;
    do @(posedge clk_i); while (!in_ready_o);
    if (op <= OP_NO_ENERGY) begin
      items_sent++;
    end
  endtask

  function automatic logic [RAND_WIDTH-1:0] pick_frac();
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) begin
      return '0;
    end else if (roll == 1) begin
      return '1;
    end
    return RAND_WIDTH'($urandom);
  endfunction

  // Mixes tick runs with control events at random so timers expire and coefficients grow.
  task automatic run_random(input int count);
    int done;
    int pick;
    int run;
    logic [OP_WIDTH-1:0] op;
    done = 0;
    while (done < count) begin
      if ($urandom_range(1) == 0) begin
        run = $urandom_range(40, 1);
        repeat (run) begin
          send_item(OP_TICK, ETX_WIDTH'($urandom), ID_WIDTH'($urandom), pick_frac());
        end
        done += run;
      end else begin
        pick = $urandom_range(99);
        if (pick < 22) op = OP_SET_ETX;
        else if (pick < 40) op = OP_NEW_PARENT;
        else if (pick < 58) op = OP_RESET;
        else if (pick < 76) op = OP_RESET_PULL;
        else if (pick < 90) op = OP_NO_ENERGY;
        else op = ($urandom_range(1) == 0) ? OP_SPARE_LO : OP_SPARE_HI;
        send_item(op, ETX_WIDTH'($urandom), ID_WIDTH'($urandom), pick_frac());
        if (op <= OP_NO_ENERGY) begin
          done++;
        end
      end
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (beacons_due_o != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  initial begin
    in_valid_i        = 1'b0;
    opcode_i          = OP_TICK;
    etx_value_i       = '0;
    parent_id_i       = '0;
    random_fraction_i = '0;
    out_ready_i       = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    hold_rx           = 1'b0;
    items_sent        = 0;
    send_idle_pct     = 37;
    recv_idle_pct     = 52;
    rst_ni            = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // power-on settings
    send_item(OP_TICK, '0, '0, '0);
    send_item(OP_SPARE_LO, '1, '1, '1);
    send_item(OP_SPARE_HI, '1, '1, '1);
    send_item(OP_SET_ETX, '1, '0, '0);
    send_item(OP_RESET, '0, '0, '0);
    send_item(OP_RESET_PULL, '0, '0, '1);
    send_item(OP_TICK, '1, '1, '1);
    send_item(OP_NEW_PARENT, '0, '1, 16'h8000);
    send_item(OP_NEW_PARENT, '1, '0, 16'h0001);
    send_item(OP_SET_ETX, '0, '1, '1);
    send_item(OP_RESET, '0, '0, '1);
    send_item(OP_NO_ENERGY, '1, '1, '1);
    send_item(OP_TICK, '0, '0, '0);
    send_item(OP_RESET_PULL, '1, '1, '0);
    send_item(OP_NO_ENERGY, '0, '0, '0);
    send_item(OP_RESET, '1, '1, 16'h7FFF);

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        drain();
        apply_setting(p);
      end
      if (p < PHASES / 3) begin
        send_idle_pct = 37;
        recv_idle_pct = 52;
      end else if (p < 2 * PHASES / 3) begin
        send_idle_pct = 52;
        recv_idle_pct = 37;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == HOLD_PHASE) begin
        fork
          begin
            hold_rx <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk_i);
            hold_rx <= 1'b0;
          end
        join_none
      end
      run_random(PHASE_ITEMS);
    end
    drain();

    $display("covered %0d events over %0d register settings, %0d beacons checked",
             items_sent, PHASES, beacon_cnt_o);
    $display("idle mixes 37/52, 52/37 and none, plus a %0d-cycle receiver hold-off",
             HOLD_CYCLES);
    if (mismatch_cnt_o == 0) begin
      $display("trickle_beacon_scheduler regression: pass");
    end else begin
      $display("trickle_beacon_scheduler regression: fail");
    end
    $finish;
  end

endmodule
